>>> rtl/prbg_pkg.sv
// Shared types and constants for the pulse repeat blink generator.
// Used by every module in rtl/; depends on nothing else.
package prbg_pkg;

    // Item kinds carried in the func field.
    typedef enum logic [3:0] {
        FUNC_TICK      = 4'd0,
        FUNC_SET_LEVEL = 4'd1,
        FUNC_ON        = 4'd2,
        FUNC_OFF       = 4'd3,
        FUNC_TOGGLE    = 4'd4,
        FUNC_START_REP = 4'd5,
        FUNC_PULSE     = 4'd6,
        FUNC_BLINK     = 4'd7,
        FUNC_SET_TIMES = 4'd8,
        FUNC_SET_ON    = 4'd9,
        FUNC_SET_OFF   = 4'd10
    } func_t;

    typedef logic signed [31:0] dur_t;
    typedef logic [30:0]        half_period_t;
    typedef logic [15:0]        rep_t;

    // Reset value of the blink half period register.
    localparam half_period_t BLINK_RESET = 31'd250000;
    // A duration of all ones (-1) disables that phase's timeout.
    localparam dur_t DUR_DISABLED = 32'hFFFF_FFFF;
    // A repetition limit of all ones means no limit.
    localparam rep_t REP_NONE = 16'hFFFF;
    localparam rep_t REP_ONE  = 16'd1;

    // One input item.
    typedef struct packed {
        func_t        func;
        logic         level_in;
        logic [14:0]  repeat_count;
        dur_t         on_duration;
        dur_t         off_duration;
    } item_t;

    // One result item.
    typedef struct packed {
        logic pin_level;
        logic rose;
        logic fell;
        logic changed;
        logic reps_done;
        dur_t on_time_now;
        dur_t off_time_now;
    } result_t;

endpackage

>>> rtl/prbg_in_stage.sv
// Input holding register of the pulse repeat blink generator.
// Depends on prbg_pkg for the item type.
module prbg_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  prbg_pkg::item_t in_item,
    output logic            item_valid,
    input  logic            item_taken_ready,
    output prbg_pkg::item_t item
);
    import prbg_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The register is free when empty or when its item moves on this cycle.
    assign in_ready   = !valid_reg || item_taken_ready;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_taken_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // The payload loads on every accepted item and needs no reset.
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/prbg_engine.sv
// Phase timer, repetition counter and result register of the generator.
// Depends on prbg_pkg for item, result and code definitions.
module prbg_engine #(
    parameter int TIME_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  prbg_pkg::item_t        item,
    input  prbg_pkg::half_period_t blink_half_period,
    output logic                   res_valid,
    input  logic                   res_ready,
    output prbg_pkg::result_t      res
);
    import prbg_pkg::*;

    localparam int PW = TIME_BITS - 1;
    localparam int CW = (PW > 31) ? PW : 31;

    // Kept state.
    logic          line_reg, line_next;
    logic [PW-1:0] ticks_reg, ticks_next;
    dur_t          on_reg, on_next;
    dur_t          off_reg, off_next;
    rep_t          rl_reg, rl_next;
    rep_t          rc_reg, rc_next;

    logic          out_valid_reg;
    result_t       res_reg;
    result_t       res_next;
    logic          advance;

    logic          req_on;
    logic          req_off;
    logic          rose;
    logic          fell;
    logic          done;
    logic [PW-1:0] tick_inc;
    logic [CW-1:0] ticks_cmp;
    logic [CW-1:0] on_cmp;
    logic [CW-1:0] off_cmp;
    rep_t          rc_inc;

    // The item in the input register is worked on when the result register can take it.
    assign item_ready = !out_valid_reg || res_ready;
    assign advance    = item_valid && item_ready;

    // Saturating tick count and its comparisons against the phase durations.
    assign tick_inc  = (ticks_reg == {PW{1'b1}}) ? ticks_reg : ticks_reg + PW'(1);
    assign ticks_cmp = CW'(tick_inc);
    assign on_cmp    = CW'(on_reg[30:0]);
    assign off_cmp   = CW'(off_reg[30:0]);
    assign rc_inc    = rc_reg + 16'd1;

    // Next state and result for the item at hand.
    always_comb begin
        line_next  = line_reg;
        ticks_next = ticks_reg;
        on_next    = on_reg;
        off_next   = off_reg;
        rl_next    = rl_reg;
        rc_next    = rc_reg;
        req_on     = 1'b0;
        req_off    = 1'b0;
        rose       = 1'b0;
        fell       = 1'b0;
        done       = 1'b0;

        unique case (item.func)
            FUNC_TICK: begin
                ticks_next = tick_inc;
                if (line_reg) begin
                    req_off = !on_reg[31] && (ticks_cmp >= on_cmp);
                end else begin
                    req_on = !off_reg[31] && (ticks_cmp >= off_cmp);
                end
            end
            FUNC_SET_LEVEL: begin
                req_on  = item.level_in;
                req_off = !item.level_in;
            end
            FUNC_ON: begin
                on_next  = DUR_DISABLED;
                off_next = DUR_DISABLED;
                req_on   = 1'b1;
            end
            FUNC_OFF: begin
                on_next  = DUR_DISABLED;
                off_next = DUR_DISABLED;
                rl_next  = REP_NONE;
                req_off  = 1'b1;
            end
            FUNC_TOGGLE: begin
                on_next  = DUR_DISABLED;
                off_next = DUR_DISABLED;
                if (line_reg) begin
                    rl_next = REP_NONE;
                    req_off = 1'b1;
                end else begin
                    req_on = 1'b1;
                end
            end
            FUNC_START_REP: begin
                line_next  = 1'b1;
                ticks_next = '0;
                on_next    = item.on_duration;
                off_next   = item.off_duration;
                rl_next    = {1'b0, item.repeat_count};
                rc_next    = '0;
            end
            FUNC_PULSE: begin
                line_next  = 1'b1;
                ticks_next = '0;
                on_next    = item.on_duration;
                off_next   = DUR_DISABLED;
                rl_next    = REP_ONE;
                rc_next    = '0;
            end
            FUNC_BLINK: begin
                line_next  = 1'b1;
                ticks_next = '0;
                on_next    = {1'b0, blink_half_period};
                off_next   = {1'b0, blink_half_period};
                rl_next    = REP_NONE;
                rc_next    = '0;
            end
            FUNC_SET_TIMES: begin
                on_next    = item.on_duration;
                off_next   = item.off_duration;
                ticks_next = '0;
            end
            FUNC_SET_ON: begin
                on_next = item.on_duration;
            end
            FUNC_SET_OFF: begin
                off_next = item.off_duration;
            end
            default: begin
            end
        endcase

        // Normal turn-on path.
        if (req_on && !line_reg) begin
            line_next  = 1'b1;
            ticks_next = '0;
            rose       = 1'b1;
        end

        // Normal turn-off path, with repetition counting under an active limit.
        if (req_off && line_reg) begin
            line_next  = 1'b0;
            ticks_next = '0;
            fell       = 1'b1;
            if (!rl_next[15]) begin
                rc_next = rc_inc;
                if (rc_inc >= rl_next) begin
                    rc_next  = '0;
                    rl_next  = REP_NONE;
                    on_next  = DUR_DISABLED;
                    off_next = DUR_DISABLED;
                    done     = 1'b1;
                end
            end
        end

        res_next.pin_level    = line_next;
        res_next.rose         = rose;
        res_next.fell         = fell;
        res_next.changed      = rose || fell;
        res_next.reps_done    = done;
        res_next.on_time_now  = on_next;
        res_next.off_time_now = off_next;
    end

    // State registers and result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg      <= 1'b0;
            ticks_reg     <= '0;
            on_reg        <= DUR_DISABLED;
            off_reg       <= DUR_DISABLED;
            rl_reg        <= REP_NONE;
            rc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                line_reg  <= line_next;
                ticks_reg <= ticks_next;
                on_reg    <= on_next;
                off_reg   <= off_next;
                rl_reg    <= rl_next;
                rc_reg    <= rc_next;
            end
            if (item_ready) begin
                out_valid_reg <= item_valid;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    // Completion only happens on a turn-off edge.
    a_done_on_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.reps_done |-> res.fell && !res.pin_level)
        else $error("reps_done without a turn-off edge");

    // Completion leaves both durations disabled.
    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.reps_done |->
            res.on_time_now == DUR_DISABLED && res.off_time_now == DUR_DISABLED)
        else $error("durations not cleared on completion");

    // The reported level matches the kept line state once the result is out.
    a_level_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && advance |=> res.pin_level == line_reg)
        else $error("result level differs from line state");

    // The kept state moves only when an item is worked on.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && !advance |=> $stable(line_reg) && $stable(rc_reg) && $stable(rl_reg))
        else $error("state changed without an item");

endmodule

>>> rtl/pulse_repeat_blink_generator.sv
// An accepted input item passes through the input register and then the result register before its result appears.
// Throughput: one item per clock while m_ready does not hold back the result side.
// A stalled result side holds up at most two items before s_ready drops.
// Reset (aresetn low, synchronous): line off, phase count zero, both durations and the
// repetition limit disabled, blink half period 250000, no item held.
module pulse_repeat_blink_generator #(
    parameter int TIME_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [30:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_func,
    input  logic               s_level_in,
    input  logic [14:0]        s_repeat_count,
    input  logic signed [31:0] s_on_duration,
    input  logic signed [31:0] s_off_duration,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_pin_level,
    output logic               m_rose,
    output logic               m_fell,
    output logic               m_changed,
    output logic               m_reps_done,
    output logic signed [31:0] m_on_time_now,
    output logic signed [31:0] m_off_time_now
);
    import prbg_pkg::*;

    half_period_t half_period_reg;
    item_t        in_item;
    item_t        item;
    logic         item_valid;
    logic         item_ready;
    result_t      res;

    // Blink half period register; always ready for a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= BLINK_RESET;
        end else if (cfg_valid && cfg_ready) begin
            half_period_reg <= cfg_data;
        end
    end

    // Gather the input fields into one item.
    assign in_item.func         = func_t'(s_func);
    assign in_item.level_in     = s_level_in;
    assign in_item.repeat_count = s_repeat_count;
    assign in_item.on_duration  = s_on_duration;
    assign in_item.off_duration = s_off_duration;

    prbg_in_stage u_in_stage (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_valid),
        .in_ready         (s_ready),
        .in_item          (in_item),
        .item_valid       (item_valid),
        .item_taken_ready (item_ready),
        .item             (item)
    );

    prbg_engine #(
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .item_valid        (item_valid),
        .item_ready        (item_ready),
        .item              (item),
        .blink_half_period (half_period_reg),
        .res_valid         (m_valid),
        .res_ready         (m_ready),
        .res               (res)
    );

    // Spread the result item onto its ports.
    assign m_pin_level    = res.pin_level;
    assign m_rose         = res.rose;
    assign m_fell         = res.fell;
    assign m_changed      = res.changed;
    assign m_reps_done    = res.reps_done;
    assign m_on_time_now  = res.on_time_now;
    assign m_off_time_now = res.off_time_now;

endmodule
